FILE: rtl/dle_shielded_voice_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// dle_shielded_voice_stream_decoder_macros.svh
// assertion macros used by the port-level checker of the stream decoder
// ----------------------------------------------------------------------------
`ifndef DLE_SHIELDED_VOICE_STREAM_DECODER_MACROS_SVH
`define DLE_SHIELDED_VOICE_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DSVD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("stream decoder check failed");

// next-cycle implication, disabled while reset is low
`define DSVD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("stream decoder check failed");

`endif

FILE: rtl/dsvd_pkg.sv
// ----------------------------------------------------------------------------
// dsvd_pkg
// shared codes and types of the shielded voice stream decoder
// ----------------------------------------------------------------------------
package dsvd_pkg;

    // shield and escape codes
    localparam logic [7:0] DLE_BYTE        = 8'h10;
    localparam logic [7:0] ETX_BYTE        = 8'h03;
    localparam logic [7:0] DTMF_START_CODE = 8'h2F;  // '/'
    localparam logic [7:0] DTMF_END_CODE   = 8'h7E;  // '~'

    // action codes
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // event kinds
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_DCE   = 3'd1;
    localparam logic [2:0] EV_DIGIT = 3'd2;
    localparam logic [2:0] EV_END   = 3'd3;
    localparam logic [2:0] EV_START = 3'd4;

    // decoder state carried between bytes
    typedef struct packed {
        logic       pending_escape;
        logic       dtmf_active;
        logic [7:0] last_digit;
    } dsvd_state_t;

    // one result transaction
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [2:0] event_kind;
        logic [7:0] event_code;
        logic       interrupt;
        logic       dtmf_on;
        logic [7:0] current_digit;
    } dsvd_result_t;

    // DTMF digit characters: 0-9, A-D, # and *
    function automatic logic is_digit_code(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            [8'h30:8'h39], [8'h41:8'h44], 8'h23, 8'h2A: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // codes reported as DCE events
    function automatic logic is_known_dce(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            ETX_BYTE, 8'h64, 8'h52, 8'h61, 8'h63, 8'h65, 8'h68, 8'h48,
            8'h73, 8'h62, 8'h40, DTMF_START_CODE, DTMF_END_CODE: hit = 1'b1;
            default: hit = is_digit_code(c);
        endcase
        return hit;
    endfunction

endpackage

FILE: rtl/dsvd_decode.sv
// ----------------------------------------------------------------------------
// dsvd_decode
// per-byte shield decode: result fields and next decoder state
// ----------------------------------------------------------------------------
module dsvd_decode
    import dsvd_pkg::*;
(
    input  logic         action,
    input  logic [7:0]   rx_byte,
    input  dsvd_state_t  state_cur,
    output dsvd_state_t  state_next,
    output dsvd_result_t result
);

    logic       dv;
    logic [7:0] db;
    logic [2:0] kind;
    logic [7:0] code;
    logic       irq;

    // escape and DTMF tracking rules
    always_comb begin
        state_next = state_cur;
        dv         = 1'b0;
        db         = '0;
        kind       = EV_NONE;
        code       = '0;
        irq        = 1'b0;
        if (action == ACT_CLEAR) begin
            state_next.dtmf_active = 1'b0;
            state_next.last_digit  = '0;
        end else if (!state_cur.pending_escape) begin
            if (rx_byte != DLE_BYTE) begin
                dv = 1'b1;
                db = rx_byte;
            end else begin
                state_next.pending_escape = 1'b1;
            end
        end else begin
            state_next.pending_escape = 1'b0;
            if (rx_byte == DLE_BYTE) begin
                dv = 1'b1;
                db = DLE_BYTE;
            end else if (rx_byte == DTMF_START_CODE) begin
                state_next.dtmf_active = 1'b1;
                kind = EV_START;
                code = rx_byte;
            end else if (rx_byte == DTMF_END_CODE) begin
                state_next.dtmf_active = 1'b0;
                state_next.last_digit  = '0;
                kind = EV_END;
                code = rx_byte;
                irq  = 1'b1;
            end else if (state_cur.dtmf_active && is_digit_code(rx_byte)) begin
                // a repeat of the tracked digit stays silent
                if (state_cur.last_digit != rx_byte) begin
                    state_next.last_digit = rx_byte;
                    kind = EV_DIGIT;
                    code = rx_byte;
                    irq  = 1'b1;
                end
            end else if (is_known_dce(rx_byte)) begin
                kind = EV_DCE;
                code = rx_byte;
                irq  = 1'b1;
            end
        end
    end

    // pack the result
    always_comb begin
        result.data_valid    = dv;
        result.data_byte     = db;
        result.event_kind    = kind;
        result.event_code    = code;
        result.interrupt     = irq;
        result.dtmf_on       = state_next.dtmf_active;
        result.current_digit = state_next.last_digit;
    end

endmodule

FILE: rtl/dle_shielded_voice_stream_decoder.sv
// ----------------------------------------------------------------------------
// dle_shielded_voice_stream_decoder
// removes DLE shielding from a modem receive stream and reports DCE/DTMF events
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// s_       | in        | s_valid / s_ready  | s_action, s_rx_byte
// m_       | out       | m_valid / m_ready  | m_data_valid, m_data_byte, m_event_kind,
//          |           |                    | m_event_code, m_interrupt, m_dtmf_on,
//          |           |                    | m_current_digit
//
// one transaction per cycle sustained while m_ready is high; the path is an input
// register, then decode into the result register
// decoder state updates when a byte moves from the input to the result register
// synchronous active-low reset clears valids and decoder state
// a stalled m_ side holds the result; the input register still takes one more
// transaction, after that s_ready follows m_ready
// ----------------------------------------------------------------------------
module dle_shielded_voice_stream_decoder
    import dsvd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_data_valid,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_event_kind,
    output logic [7:0] m_event_code,
    output logic       m_interrupt,
    output logic       m_dtmf_on,
    output logic [7:0] m_current_digit
);

    logic         in_valid_reg;
    logic         in_action_reg;
    logic [7:0]   in_byte_reg;
    dsvd_state_t  state_reg;
    dsvd_state_t  state_next;
    logic         out_valid_reg;
    dsvd_result_t out_reg;
    dsvd_result_t result_next;
    logic         advance;

    // handshake control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_byte_reg   <= s_rx_byte;
        end
    end

    // decode
    dsvd_decode u_decode (
        .action     (in_action_reg),
        .rx_byte    (in_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    // output ports
    assign m_valid         = out_valid_reg;
    assign m_data_valid    = out_reg.data_valid;
    assign m_data_byte     = out_reg.data_byte;
    assign m_event_kind    = out_reg.event_kind;
    assign m_event_code    = out_reg.event_code;
    assign m_interrupt     = out_reg.interrupt;
    assign m_dtmf_on       = out_reg.dtmf_on;
    assign m_current_digit = out_reg.current_digit;

endmodule

FILE: rtl/dsvd_checker.sv
// ----------------------------------------------------------------------------
// dsvd_checker
// port-level checks of the stream decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "dle_shielded_voice_stream_decoder_macros.svh"

module dsvd_checker
    import dsvd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_data_valid,
    input logic [7:0] m_data_byte,
    input logic [2:0] m_event_kind,
    input logic [7:0] m_event_code,
    input logic       m_interrupt,
    input logic       m_dtmf_on,
    input logic [7:0] m_current_digit
);

    logic        out_stall;
    logic [29:0] out_payload;
    logic        irq_kind_ok;
    logic        event_free;
    logic        end_cleared;
    logic        digit_tracked;

    // terms used by the checks below
    assign out_stall     = m_valid && !m_ready;
    assign out_payload   = {m_data_valid, m_data_byte, m_event_kind, m_event_code,
                            m_interrupt, m_dtmf_on, m_current_digit};
    assign irq_kind_ok   = (m_event_kind == EV_DCE) || (m_event_kind == EV_DIGIT) ||
                           (m_event_kind == EV_END);
    assign event_free    = (m_event_kind == EV_NONE) && !m_interrupt;
    assign end_cleared   = !m_dtmf_on && (m_current_digit == 8'h00);
    assign digit_tracked = m_dtmf_on && (m_current_digit == m_event_code);

    // a stalled result keeps its payload
    `DSVD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(out_payload))

    // interrupt only for DCE, digit and end events
    `DSVD_ASSERT_NOW(a_irq_kind, aclk, aresetn, m_valid && m_interrupt, irq_kind_ok)

    // payload byte and event never share a transaction
    `DSVD_ASSERT_NOW(a_data_no_event, aclk, aresetn, m_valid && m_data_valid, event_free)

    // DTMF end leaves the mode off with no tracked digit
    `DSVD_ASSERT_NOW(a_end_clears, aclk, aresetn, m_valid && m_event_kind == EV_END, end_cleared)

    // a digit event tracks the reported digit in DTMF mode
    `DSVD_ASSERT_NOW(a_digit_track, aclk, aresetn, m_valid && m_event_kind == EV_DIGIT, digit_tracked)

endmodule

bind dle_shielded_voice_stream_decoder dsvd_checker u_dsvd_checker (.*);

FILE: test/dle_shielded_voice_stream_decoder_checker.sv
// ----------------------------------------------------------------------------
// dle_shielded_voice_stream_decoder_checker
// watches both channels of the stream decoder, decodes every accepted input
// transaction on its own copy of the escape and DTMF state, and compares each
// result transaction field by field with the oldest decoded expectation
// ----------------------------------------------------------------------------
module dle_shielded_voice_stream_decoder_checker
    import dsvd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_data_valid,
    input  logic [7:0] m_data_byte,
    input  logic [2:0] m_event_kind,
    input  logic [7:0] m_event_code,
    input  logic       m_interrupt,
    input  logic       m_dtmf_on,
    input  logic [7:0] m_current_digit,
    output int         error_count,
    output int         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state as this checker sees it
    logic       esc_open;
    logic       tone_mode;
    logic [7:0] tone_digit;

    dsvd_result_t decoded_q[$];
    int           errors;

    // DTMF tone characters
    function automatic logic is_tone_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "D") || c == "#" || c == "*";
    endfunction

    // escaped codes that raise a DCE event (start and end are handled before)
    function automatic logic is_dce_char(input logic [7:0] c);
        case (c)
            ETX_BYTE, "d", "R", "a", "c", "e", "h", "H", "s", "b", "@": return 1'b1;
            default: return is_tone_char(c);
        endcase
    endfunction

    // decode one input transaction, advancing the local state
    function automatic dsvd_result_t decode_step(input logic act, input logic [7:0] ch);
        dsvd_result_t r;
        r = '0;
        if (act == ACT_CLEAR) begin
            tone_mode  = 1'b0;
            tone_digit = 8'h00;
        end else if (!esc_open) begin
            if (ch == DLE_BYTE) begin
                esc_open = 1'b1;
            end else begin
                r.data_valid = 1'b1;
                r.data_byte  = ch;
            end
        end else begin
            esc_open = 1'b0;
            if (ch == DLE_BYTE) begin
                r.data_valid = 1'b1;
                r.data_byte  = DLE_BYTE;
            end else if (ch == DTMF_START_CODE) begin
                tone_mode    = 1'b1;
                r.event_kind = EV_START;
                r.event_code = ch;
            end else if (ch == DTMF_END_CODE) begin
                tone_mode    = 1'b0;
                tone_digit   = 8'h00;
                r.event_kind = EV_END;
                r.event_code = ch;
                r.interrupt  = 1'b1;
            end else if (tone_mode && is_tone_char(ch)) begin
                // repeat of the tracked digit stays silent
                if (tone_digit != ch) begin
                    tone_digit   = ch;
                    r.event_kind = EV_DIGIT;
                    r.event_code = ch;
                    r.interrupt  = 1'b1;
                end
            end else if (is_dce_char(ch)) begin
                r.event_kind = EV_DCE;
                r.event_code = ch;
                r.interrupt  = 1'b1;
            end
        end
        r.dtmf_on       = tone_mode;
        r.current_digit = tone_digit;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    initial errors = 0;

    // sample both channels at each rising edge
    always @(posedge aclk) begin : monitor
        dsvd_result_t want;
        if (!aresetn) begin
            esc_open   = 1'b0;
            tone_mode  = 1'b0;
            tone_digit = 8'h00;
            decoded_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                decoded_q.push_back(decode_step(s_action, s_rx_byte));
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %0h",
                             $time, {m_data_valid, m_data_byte, m_event_kind, m_event_code,
                                     m_interrupt, m_dtmf_on, m_current_digit});
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("data_valid", want.data_valid, m_data_valid);
                    compare_field("data_byte", want.data_byte, m_data_byte);
                    compare_field("event_kind", want.event_kind, m_event_kind);
                    compare_field("event_code", want.event_code, m_event_code);
                    compare_field("interrupt", want.interrupt, m_interrupt);
                    compare_field("dtmf_on", want.dtmf_on, m_dtmf_on);
                    compare_field("current_digit", want.current_digit, m_current_digit);
                end
            end
        end
        error_count     <= errors;
        pending_results <= decoded_q.size();
    end

endmodule

FILE: test/dle_shielded_voice_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// dle_shielded_voice_stream_decoder_test
// drives directed shield sequences, then random well-formed escape traffic
// with clear actions and noise, under bursty input and a stalling receiver;
// the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module dle_shielded_voice_stream_decoder_test;
    import dsvd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_BURSTY} rx_mode_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic       s_action  = ACT_BYTE;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_data_valid;
    logic [7:0] m_data_byte;
    logic [2:0] m_event_kind;
    logic [7:0] m_event_code;
    logic       m_interrupt;
    logic       m_dtmf_on;
    logic [7:0] m_current_digit;

    int error_count;
    int pending_results;
    int cycle_count = 0;
    int burst_left  = 0;

    dle_shielded_voice_stream_decoder DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_valid   (m_data_valid),
        .m_data_byte    (m_data_byte),
        .m_event_kind   (m_event_kind),
        .m_event_code   (m_event_code),
        .m_interrupt    (m_interrupt),
        .m_dtmf_on      (m_dtmf_on),
        .m_current_digit(m_current_digit)
    );

    dle_shielded_voice_stream_decoder_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_valid   (m_data_valid),
        .m_data_byte    (m_data_byte),
        .m_event_kind   (m_event_kind),
        .m_event_code   (m_event_code),
        .m_interrupt    (m_interrupt),
        .m_dtmf_on      (m_dtmf_on),
        .m_current_digit(m_current_digit),
        .error_count    (error_count),
        .pending_results(pending_results)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern: steady, coin toss or long stall runs
    rx_mode_t rx_mode   = RX_STEADY;
    int       mode_left = 0;
    int       stall_left = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (rx_mode)
            RX_STEADY: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 12);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // one input transaction, then either stay in the burst or take a gap
    task automatic drive_item(input logic act, input logic [7:0] b);
        s_valid   <= 1'b1;
        s_action  <= act;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // hold the sender until every expected result has come
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    string      tone_chars = "0123456789ABCD#*";
    string      dce_chars  = "dRacehHsb@";
    int         items_sent;
    int         roll;
    logic [7:0] code;
    logic [7:0] last_tone;

    initial begin
        last_tone = "5";
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain bytes: the extremes and alternating patterns
        drive_item(ACT_BYTE, 8'h00);
        drive_item(ACT_BYTE, 8'hFF);
        drive_item(ACT_BYTE, 8'h55);
        drive_item(ACT_BYTE, 8'hAA);
        // shielded DLE
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, DLE_BYTE);
        // DTMF start, then start again while already on
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, DTMF_START_CODE);
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, DTMF_START_CODE);
        // digit, silent repeat, digit change, non-digit code in DTMF mode
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, "5");
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, "5");
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, "#");
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, "a");
        // clear, then DTMF end while off
        drive_item(ACT_CLEAR, 8'hFF);
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, DTMF_END_CODE);
        // lone DLE kept across a clear, then unknown code, then ETX
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_CLEAR, 8'h00);
        drive_item(ACT_BYTE, "Z");
        drive_item(ACT_BYTE, DLE_BYTE);
        drive_item(ACT_BYTE, ETX_BYTE);
        wait_for_results();

        // random traffic, mostly plain bytes and well-formed escape pairs
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                code = 8'($urandom_range(0, 255));
                if (code == DLE_BYTE) code = ~code;
                drive_item(ACT_BYTE, code);
                items_sent++;
            end else if (roll < 85) begin
                case ($urandom_range(0, 9))
                    0: code = DLE_BYTE;
                    1: code = DTMF_START_CODE;
                    2: code = DTMF_END_CODE;
                    3, 4: begin
                        code      = tone_chars[$urandom_range(0, tone_chars.len() - 1)];
                        last_tone = code;
                    end
                    5: code = last_tone;
                    6: code = dce_chars[$urandom_range(0, dce_chars.len() - 1)];
                    7: code = ETX_BYTE;
                    default: code = 8'($urandom_range(0, 255));
                endcase
                drive_item(ACT_BYTE, DLE_BYTE);
                // a clear between DLE and its code now and then
                if ($urandom_range(0, 7) == 0) begin
                    drive_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
                    items_sent++;
                end
                drive_item(ACT_BYTE, code);
                items_sent += 2;
            end else if (roll < 93) begin
                drive_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
                items_sent++;
            end else begin
                drive_item(ACT_BYTE, 8'($urandom_range(0, 255)));
                items_sent++;
            end
            if (items_sent % 500 < 3 && items_sent > 3 && $urandom_range(0, 1) == 0) begin
                wait_for_results();
            end
        end

        // drain and settle
        wait_for_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: dle_shielded_voice_stream_decoder.f
+incdir+rtl
rtl/dsvd_pkg.sv
rtl/dsvd_decode.sv
rtl/dle_shielded_voice_stream_decoder.sv
rtl/dsvd_checker.sv
test/dle_shielded_voice_stream_decoder_checker.sv
test/dle_shielded_voice_stream_decoder_test.sv
